// ----- sv/sphere_frustum_cull_core_defines.svh -----
// Assertion macros shared by the sphere frustum culling RTL.
`ifndef SPHERE_FRUSTUM_CULL_CORE_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define SFC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define SFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/sfc_pkg.sv -----
// Types and widths shared by the sphere frustum culling core.
package sfc_pkg;

   // Field widths
   localparam int NORMAL_W = 18;
   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 31;
   localparam int INDEX_W  = 3;
   localparam int FRAC_W   = 16;

   // Normal times coordinate, then the partial and full sums
   localparam int PROD_W = NORMAL_W + COORD_W;
   localparam int PSUM_W = PROD_W + 1;
   localparam int DIST_W = PROD_W + 2;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TEST = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      VERDICT_INSIDE    = 2'd0,
      VERDICT_INTERSECT = 2'd1,
      VERDICT_OUTSIDE   = 2'd2
   } verdict_type;

endpackage

// ----- sv/sphere_frustum_cull_core.sv -----
// Sphere against frustum classifier: plane store and four-stage test pipeline.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   req     | in        | req_valid/req_ready | opcode, plane index, normal, offset, sphere
//   rsp     | out       | rsp_valid/rsp_ready | verdict (test items only)
//
// One item per cycle sustained while rsp_ready holds; a test result goes from acceptance
// through multiply stage, two adder stages, compare-and-reduce into the output register.
// Loads write the plane store at acceptance (valid index only); none enters the pipeline.
// Reset clears every stage valid bit and zeroes the plane store.
// Stalls hold back stage by stage: a stage loads when it is empty or the stage after
// it moves, so bubbles close up while a result waits at the output.
module sphere_frustum_cull_core #(
   parameter int NUM_PLANES = 6
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  sfc_pkg::opcode_type                     req_opcode,
   input  logic        [sfc_pkg::INDEX_W-1:0]      req_plane_index,
   input  logic signed [sfc_pkg::NORMAL_W-1:0]     req_normal_x,
   input  logic signed [sfc_pkg::NORMAL_W-1:0]     req_normal_y,
   input  logic signed [sfc_pkg::NORMAL_W-1:0]     req_normal_z,
   input  logic signed [sfc_pkg::COORD_W-1:0]      req_plane_offset,
   input  logic signed [sfc_pkg::COORD_W-1:0]      req_center_x,
   input  logic signed [sfc_pkg::COORD_W-1:0]      req_center_y,
   input  logic signed [sfc_pkg::COORD_W-1:0]      req_center_z,
   input  logic        [sfc_pkg::RADIUS_W-1:0]     req_radius,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output sfc_pkg::verdict_type                    rsp_verdict
);

   import sfc_pkg::*;

   `include "sphere_frustum_cull_core_defines.svh"

   // Plane store
   logic signed [NORMAL_W-1:0] pnx_ff [NUM_PLANES];
   logic signed [NORMAL_W-1:0] pny_ff [NUM_PLANES];
   logic signed [NORMAL_W-1:0] pnz_ff [NUM_PLANES];
   logic signed [COORD_W-1:0]  pd_ff  [NUM_PLANES];

   // Stage 1: products
   logic                       v1_ff, v1_in;
   logic signed [PROD_W-1:0]   px1_ff [NUM_PLANES];
   logic signed [PROD_W-1:0]   px1_in [NUM_PLANES];
   logic signed [PROD_W-1:0]   py1_ff [NUM_PLANES];
   logic signed [PROD_W-1:0]   py1_in [NUM_PLANES];
   logic signed [PROD_W-1:0]   pz1_ff [NUM_PLANES];
   logic signed [PROD_W-1:0]   pz1_in [NUM_PLANES];
   logic signed [COORD_W-1:0]  pd1_ff [NUM_PLANES];
   logic signed [COORD_W-1:0]  pd1_in [NUM_PLANES];
   logic        [RADIUS_W-1:0] r1_ff, r1_in;

   // Stage 2: pair sums
   logic                       v2_ff, v2_in;
   logic signed [PSUM_W-1:0]   sa2_ff [NUM_PLANES];
   logic signed [PSUM_W-1:0]   sa2_in [NUM_PLANES];
   logic signed [PSUM_W-1:0]   sb2_ff [NUM_PLANES];
   logic signed [PSUM_W-1:0]   sb2_in [NUM_PLANES];
   logic        [RADIUS_W-1:0] r2_ff, r2_in;

   // Stage 3: distances
   logic                       v3_ff, v3_in;
   logic signed [DIST_W-1:0]   dist3_ff [NUM_PLANES];
   logic signed [DIST_W-1:0]   dist3_in [NUM_PLANES];
   logic        [RADIUS_W-1:0] r3_ff, r3_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   verdict_type                verdict_ff, verdict_in;

   // Stage enables
   logic en_out, en3, en2, en1;
   logic req_fire, load_fire, test_fire;

   // Backpressure, stage by stage
   always_comb begin
      en_out    = !rsp_valid_ff || rsp_ready;
      en3       = !v3_ff || en_out;
      en2       = !v2_ff || en3;
      en1       = !v1_ff || en2;
      req_fire  = req_valid && en1;
      test_fire = req_fire && (req_opcode == OP_TEST);
      load_fire = req_fire && (req_opcode == OP_LOAD) && (int'(req_plane_index) < NUM_PLANES);
   end

   assign req_ready   = en1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   // Plane store write, zero at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            pnx_ff[i] <= '0;
            pny_ff[i] <= '0;
            pnz_ff[i] <= '0;
            pd_ff[i]  <= '0;
         end
      end else if (load_fire) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            if (int'(req_plane_index) == i) begin
               pnx_ff[i] <= req_normal_x;
               pny_ff[i] <= req_normal_y;
               pnz_ff[i] <= req_normal_z;
               pd_ff[i]  <= req_plane_offset;
            end
         end
      end
   end

   // Stage 1 next: one product per axis per plane
   always_comb begin
      v1_in = test_fire;
      r1_in = req_radius;
      for (int i = 0; i < NUM_PLANES; i++) begin
         px1_in[i] = PROD_W'(pnx_ff[i]) * PROD_W'(req_center_x);
         py1_in[i] = PROD_W'(pny_ff[i]) * PROD_W'(req_center_y);
         pz1_in[i] = PROD_W'(pnz_ff[i]) * PROD_W'(req_center_z);
         pd1_in[i] = pd_ff[i];
      end
   end

   // Stage 2 next: x plus y, z plus scaled offset
   always_comb begin
      v2_in = v1_ff;
      r2_in = r1_ff;
      for (int i = 0; i < NUM_PLANES; i++) begin
         sa2_in[i] = PSUM_W'(px1_ff[i]) + PSUM_W'(py1_ff[i]);
         sb2_in[i] = PSUM_W'(pz1_ff[i]) + PSUM_W'($signed({pd1_ff[i], {FRAC_W{1'b0}}}));
      end
   end

   // Stage 3 next: full distance
   always_comb begin
      v3_in = v2_ff;
      r3_in = r2_ff;
      for (int i = 0; i < NUM_PLANES; i++) begin
         dist3_in[i] = DIST_W'(sa2_ff[i]) + DIST_W'(sb2_ff[i]);
      end
   end

   // Compare against plus and minus radius, then reduce over planes
   always_comb begin
      logic signed [DIST_W-1:0] r_pos;
      logic signed [DIST_W-1:0] r_neg;
      logic                     any_out;
      logic                     any_cross;
      r_pos     = $signed(DIST_W'({r3_ff, {FRAC_W{1'b0}}}));
      r_neg     = -r_pos;
      any_out   = 1'b0;
      any_cross = 1'b0;
      for (int i = 0; i < NUM_PLANES; i++) begin
         any_out   = any_out   || (dist3_ff[i] < r_neg);
         any_cross = any_cross || (dist3_ff[i] < r_pos);
      end
      rsp_valid_in = v3_ff;
      priority if (any_out) begin
         verdict_in = VERDICT_OUTSIDE;
      end else if (any_cross) begin
         verdict_in = VERDICT_INTERSECT;
      end else begin
         verdict_in = VERDICT_INSIDE;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= v1_in;
         end
         if (en2) begin
            v2_ff <= v2_in;
         end
         if (en3) begin
            v3_ff <= v3_in;
         end
         if (en_out) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (en1) begin
         r1_ff <= r1_in;
         for (int i = 0; i < NUM_PLANES; i++) begin
            px1_ff[i] <= px1_in[i];
            py1_ff[i] <= py1_in[i];
            pz1_ff[i] <= pz1_in[i];
            pd1_ff[i] <= pd1_in[i];
         end
      end
      if (en2) begin
         r2_ff <= r2_in;
         for (int i = 0; i < NUM_PLANES; i++) begin
            sa2_ff[i] <= sa2_in[i];
            sb2_ff[i] <= sb2_in[i];
         end
      end
      if (en3) begin
         r3_ff <= r3_in;
         for (int i = 0; i < NUM_PLANES; i++) begin
            dist3_ff[i] <= dist3_in[i];
         end
      end
      if (en_out) begin
         verdict_ff <= verdict_in;
      end
   end

   // Checks
   `SFC_ASSERT_NEXT(a_load_no_item, req_fire && (req_opcode == OP_LOAD), !v1_ff,
      "load item entered the test pipeline")
   `SFC_ASSERT_NEXT(a_stage1_hold, v1_ff && !en2, v1_ff && $stable(r1_ff),
      "stage 1 item lost or changed while stalled")
   `SFC_ASSERT_NEXT(a_point_no_cross, en_out && v3_ff && (r3_ff == '0),
      rsp_verdict != VERDICT_INTERSECT, "point test gave intersect")
   `SFC_ASSERT_IMPLY(a_empty_ready, !v1_ff, req_ready,
      "empty first stage refused an item")

endmodule
